FILE: rtl/fbc_pkg.sv
// Package for frustum_box_cull: shared constants, widths and types.
// No dependencies.
`default_nettype none
package fbc_pkg;
  localparam int CHUNK_SIZE     = 32;
  localparam int COEF_FRAC_BITS = 16;
  localparam int COORD_W        = 16;
  localparam int ELEM_W         = 32;
  localparam int COEF_W         = ELEM_W + 1;
  localparam int PV_W           = COORD_W + $clog2(CHUNK_SIZE) + 2;
  localparam int PROD_W         = COEF_W + PV_W;
  localparam int DOT_W          = 64;
  localparam int S_DATA_W       = 88;
  localparam int M_DATA_W       = 8;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TEST = 1'b1;

  typedef logic [15:0][ELEM_W-1:0] mat_t;

  typedef struct packed {
    logic                      valid;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } q_word_t;

  typedef struct packed {
    logic pop;
    logic busy;
  } back_stat_t;
endpackage
`default_nettype wire

FILE: rtl/fbc_front.sv
// Front end: accepts words, holds the matrix store and a two-entry test queue.
// Depends on fbc_pkg.
`default_nettype none
module fbc_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_valid_i,
  output logic                               s_ready_o,
  input  wire logic                          cmd_i,
  input  wire logic [fbc_pkg::S_DATA_W-1:0]  data_i,
  input  wire fbc_pkg::back_stat_t           stat_i,
  output fbc_pkg::q_word_t                   q_o,
  output fbc_pkg::mat_t                      mat_o
);
  fbc_pkg::mat_t mat_q;
  logic [1:0][3*fbc_pkg::COORD_W-1:0] fifo_q;
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       acc, push, pop;

  // loads wait until no test depends on the old matrix
  assign s_ready_o = (cmd_i == fbc_pkg::CMD_TEST) ? (cnt_q != 2'd2)
                   : ((cnt_q == 2'd0) && !stat_i.busy);
  assign acc  = s_valid_i && s_ready_o;
  assign push = acc && (cmd_i == fbc_pkg::CMD_TEST);
  assign pop  = stat_i.pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q <= '0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (acc && (cmd_i == fbc_pkg::CMD_LOAD)) begin
        mat_q[{data_i[1:0], data_i[3:2]}] <= data_i[35:4];
      end
      if (push) begin
        wr_q <= !wr_q;
      end
      if (pop) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= data_i[83:36];
    end
  end

  always_comb begin
    q_o.valid = (cnt_q != 2'd0);
    q_o.x     = fifo_q[rd_q][15:0];
    q_o.y     = fifo_q[rd_q][31:16];
    q_o.z     = fifo_q[rd_q][47:32];
  end
  assign mat_o = mat_q;
endmodule
`default_nettype wire

FILE: rtl/fbc_back.sv
// Back end: three plane lanes of three multipliers, two passes per test, then sum and compare.
// Depends on fbc_pkg.
`default_nettype none
module fbc_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire fbc_pkg::q_word_t   q_i,
  input  wire fbc_pkg::mat_t      mat_i,
  output fbc_pkg::back_stat_t     stat_o,
  output logic                    m_valid_o,
  input  wire logic               m_ready_i,
  output logic                    visible_o
);
  localparam logic signed [fbc_pkg::PV_W-1:0] CS = fbc_pkg::PV_W'(fbc_pkg::CHUNK_SIZE);

  logic v1_q, ph_q;
  logic signed [2:0][fbc_pkg::COORD_W-1:0] crd_q;
  logic p2_q, last_q, acc_q, out_q, vis_q;
  logic adv, take, fail;

  // one plane per lane per pass: lane r pairs row r with row 3; products and offset summed later
  logic signed [2:0][2:0][fbc_pkg::PROD_W-1:0] lp_q;
  logic signed [2:0][fbc_pkg::COEF_W-1:0]      ld_q;
  logic signed [2:0][2:0][fbc_pkg::PROD_W-1:0] lp_d;
  logic signed [2:0][fbc_pkg::COEF_W-1:0]      ld_d;

  always_comb begin
    logic signed [fbc_pkg::COEF_W-1:0] a, b, c;
    logic signed [fbc_pkg::PV_W-1:0]   lo, pv;
    lo = '0;
    pv = '0;
    for (int r = 0; r < 3; r++) begin
      for (int col = 0; col < 4; col++) begin
        a = fbc_pkg::COEF_W'($signed(mat_i[col*4+3]));
        b = fbc_pkg::COEF_W'($signed(mat_i[col*4+r]));
        c = ph_q ? (a - b) : (a + b);
        if (col == 3) begin
          ld_d[r] = c;
        end else begin
          lo = fbc_pkg::PV_W'($signed(crd_q[col])) * CS;
          pv = lo + ((c >= 0) ? CS : '0);
          lp_d[r][col] = fbc_pkg::PROD_W'(c) * fbc_pkg::PROD_W'(pv);
        end
      end
    end
  end

  always_comb begin
    logic signed [fbc_pkg::DOT_W-1:0] s;
    fail = 1'b0;
    for (int r = 0; r < 3; r++) begin
      s = fbc_pkg::DOT_W'($signed(lp_q[r][0])) + fbc_pkg::DOT_W'($signed(lp_q[r][1]))
        + fbc_pkg::DOT_W'($signed(lp_q[r][2])) + fbc_pkg::DOT_W'($signed(ld_q[r]));
      if (s < 0) fail = 1'b1;
    end
  end

  assign adv  = !(out_q && !m_ready_i);
  assign take = adv && (!v1_q || ph_q) && q_i.valid;
  assign stat_o.pop  = take;
  assign stat_o.busy = v1_q || p2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      ph_q   <= 1'b0;
      p2_q   <= 1'b0;
      last_q <= 1'b0;
      acc_q  <= 1'b0;
      out_q  <= 1'b0;
      vis_q  <= 1'b0;
    end else begin
      if (adv) begin
        p2_q   <= v1_q;
        last_q <= ph_q;
        out_q  <= p2_q && last_q;
        if (v1_q && !ph_q) begin
          ph_q <= 1'b1;
        end else begin
          v1_q <= q_i.valid;
          ph_q <= 1'b0;
        end
        if (p2_q) begin
          if (last_q) begin
            vis_q <= !(acc_q || fail);
          end else begin
            acc_q <= fail;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      crd_q[0] <= q_i.x;
      crd_q[1] <= q_i.y;
      crd_q[2] <= q_i.z;
    end
    if (adv) begin
      lp_q <= lp_d;
      ld_q <= ld_d;
    end
  end

  assign m_valid_o = out_q;
  assign visible_o = vis_q;
endmodule
`default_nettype wire

FILE: rtl/frustum_box_cull.sv
// Top level of frustum_box_cull: front end, test queue and back end.
// Depends on fbc_pkg, fbc_front, fbc_back.
// Load words write one Q16.16 element of the column-major matrix; test words give one
// visibility word. A test occupies the shared multiplier lanes for two passes (plus
// planes, then minus planes); the next test is taken in the minus pass. Products, the
// plus-pass verdict and result are registered; loads wait for queued tests to end.
`default_nettype none
module frustum_box_cull (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: elem_col[1:0] elem_row[3:2] elem_value[35:4] chunk_x[51:36]
  //        chunk_y[67:52] chunk_z[83:68], zero fill
  input  wire logic [fbc_pkg::S_DATA_W-1:0] s_axis_tdata,
  // tuser: cmd
  input  wire logic                         s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // tdata: visible[0], zero fill
  output logic [fbc_pkg::M_DATA_W-1:0]      m_axis_tdata
);
  fbc_pkg::q_word_t    q;
  fbc_pkg::mat_t       mat;
  fbc_pkg::back_stat_t stat;
  logic                vis;

  fbc_front u_front (
    .clk_i, .rst_ni,
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .cmd_i     (s_axis_tuser),
    .data_i    (s_axis_tdata),
    .stat_i    (stat),
    .q_o       (q),
    .mat_o     (mat)
  );

  fbc_back u_back (
    .clk_i, .rst_ni,
    .q_i       (q),
    .mat_i     (mat),
    .stat_o    (stat),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .visible_o (vis)
  );

  assign m_axis_tdata = {{(fbc_pkg::M_DATA_W-1){1'b0}}, vis};
endmodule
`default_nettype wire

FILE: rtl/fbc_checker.sv
// Port checker for frustum_box_cull and its bind.
// Depends on frustum_box_cull ports only.
`default_nettype none
module fbc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [7:0]  m_axis_tdata
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word dropped");
  a_load_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> !$rose(m_axis_tvalid))
    else $error("result after load");
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[7:1] == 7'd0)
    else $error("fill bits set");
endmodule

bind frustum_box_cull fbc_checker u_fbc_checker (.*);
`default_nettype wire
